// ----- rtl/spo_pkg.sv -----
// Package for the signed permutation orbit block.
// Holds widths, limits, phase codes and the controller/datapath structs.
// No dependencies.
package spo_pkg;

    localparam int unsigned INDEX_MAX = 1023;
    localparam int unsigned IDX_W     = 10;
    localparam int unsigned ENT_W     = 11;
    localparam int unsigned SIZE_W    = 6;
    localparam int unsigned SIGN_W    = 3;

    localparam logic [1:0] ROT_NONE  = 2'd0;
    localparam logic [1:0] ROT_LEFT  = 2'd1;
    localparam logic [1:0] ROT_RIGHT = 2'd2;

    typedef struct packed {
        logic load;
        logic advance;
    } spo_cmd_t;

    typedef struct packed {
        logic last;
    } spo_status_t;

endpackage

// ----- rtl/spo_datapath.sv -----
// Datapath of the signed permutation orbit block: holds the triple, the
// sign/rotation/swap counters and forms each result. Depends on spo_pkg.
module spo_datapath
    import spo_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  spo_cmd_t                 cmd,
    input  logic [IDX_W-1:0]         first_in,
    input  logic [IDX_W-1:0]         second_in,
    input  logic [IDX_W-1:0]         third_in,
    output spo_status_t              status,
    output logic signed [ENT_W-1:0]  out_first,
    output logic signed [ENT_W-1:0]  out_second,
    output logic signed [ENT_W-1:0]  out_third,
    output logic [SIZE_W-1:0]        orbit_size,
    output logic                     last_one,
    output logic                     order_error
);

    logic [IDX_W-1:0]  a_reg, b_reg, c_reg;
    logic              err_reg, err_next;
    logic              multi_reg, multi_next;
    logic              distinct_reg, distinct_next;
    logic [SIGN_W-1:0] idx_reg, idx_next;
    logic [1:0]        rot_reg, rot_next;
    logic              swap_reg, swap_next;

    logic [SIGN_W-1:0]       smask;
    logic                    idx_end;
    logic signed [ENT_W-1:0] p, q, r;
    logic signed [ENT_W-1:0] e0, e1, e2;
    logic [SIZE_W-1:0]       base, triple;

    assign smask   = {c_reg != '0, b_reg != '0, a_reg != '0};
    assign idx_end = (idx_reg == smask);

    always_comb
    begin
        err_next      = err_reg;
        multi_next    = multi_reg;
        distinct_next = distinct_reg;
        idx_next      = idx_reg;
        rot_next      = rot_reg;
        swap_next     = swap_reg;
        if (cmd.load)
        begin
            err_next      = (first_in < second_in) || (second_in < third_in)
                            || (32'(first_in) > INDEX_MAX);
            multi_next    = !((first_in == second_in) && (second_in == third_in));
            distinct_next = (first_in != second_in) && (second_in != third_in);
            idx_next      = '0;
            rot_next      = ROT_NONE;
            swap_next     = 1'b0;
        end
        else if (cmd.advance)
        begin
            unique case (rot_reg)
                ROT_NONE:
                begin
                    if (idx_end)
                    begin
                        idx_next = '0;
                        rot_next = ROT_LEFT;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                ROT_LEFT:
                begin
                    rot_next = ROT_RIGHT;
                end
                ROT_RIGHT:
                begin
                    if (idx_end)
                    begin
                        idx_next  = '0;
                        rot_next  = ROT_NONE;
                        swap_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        rot_next = ROT_LEFT;
                    end
                end
                default:
                begin
                    rot_next = ROT_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg      <= 1'b0;
            multi_reg    <= 1'b0;
            distinct_reg <= 1'b0;
            idx_reg      <= '0;
            rot_reg      <= ROT_NONE;
            swap_reg     <= 1'b0;
        end
        else
        begin
            err_reg      <= err_next;
            multi_reg    <= multi_next;
            distinct_reg <= distinct_next;
            idx_reg      <= idx_next;
            rot_reg      <= rot_next;
            swap_reg     <= swap_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg <= first_in;
            b_reg <= second_in;
            c_reg <= third_in;
        end
    end

    // sign element: nonzero entries form a prefix, so index bits map directly
    assign p = idx_reg[0] ? -$signed({1'b0, a_reg}) : $signed({1'b0, a_reg});
    assign q = idx_reg[1] ? -$signed({1'b0, b_reg}) : $signed({1'b0, b_reg});
    assign r = idx_reg[2] ? -$signed({1'b0, c_reg}) : $signed({1'b0, c_reg});

    always_comb
    begin
        unique case (rot_reg)
            ROT_LEFT:
            begin
                e0 = q;
                e1 = r;
                e2 = p;
            end
            ROT_RIGHT:
            begin
                e0 = r;
                e1 = p;
                e2 = q;
            end
            default:
            begin
                e0 = p;
                e1 = q;
                e2 = r;
            end
        endcase
    end

    assign base   = SIZE_W'(smask) + SIZE_W'(1);
    assign triple = (base << 1) + base;

    always_comb
    begin
        if (err_reg)
        begin
            out_first  = '0;
            out_second = '0;
            out_third  = '0;
            orbit_size = SIZE_W'(1);
        end
        else
        begin
            out_first  = swap_reg ? e1 : e0;
            out_second = swap_reg ? e0 : e1;
            out_third  = e2;
            if (!multi_reg)
                orbit_size = base;
            else if (!distinct_reg)
                orbit_size = triple;
            else
                orbit_size = triple << 1;
        end
    end

    assign status.last = err_reg
                         || (rot_reg == ROT_NONE && idx_end && !multi_reg)
                         || (rot_reg == ROT_RIGHT && idx_end && (!distinct_reg || swap_reg));
    assign last_one    = status.last;
    assign order_error = err_reg;

endmodule

// ----- rtl/spo_ctrl.sv -----
// Controller of the signed permutation orbit block: takes one request,
// runs the datapath until the last result is taken. Depends on spo_pkg.
module spo_ctrl
    import spo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  spo_status_t status,
    output spo_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic state_reg, state_next;

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = (state_reg == ST_RUN);
    assign cmd.load    = in_valid && in_ready;
    assign cmd.advance = out_valid && out_ready && !status.last;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (out_ready && status.last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ----- rtl/signed_permutation_orbit.sv -----
// Top level of the signed permutation orbit block.
// Joins spo_ctrl and spo_datapath; depends on spo_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready, first_in/second_in/third_in) takes one
//   request: an index triple a >= b >= c. Output channel (out_valid/out_ready)
//   returns every distinct signed permutation of it in a fixed order, one
//   per handshake, each with orbit_size and last_one on the final result.
//   A triple that breaks the ordering returns one all-zero result with
//   order_error set, orbit_size 1 and last_one set.
// Timing:
//   The first result is valid in the cycle after the request is taken. With
//   out_ready held high a result leaves every cycle; in_ready is high only
//   while no result is pending. The rate is set by the sign/rotation/swap
//   counters, which step once per accepted result before the last and
//   decode straight to the result ports.
// Reset and stall:
//   rst_n clears the controller and counters; the block comes up idle with
//   in_ready high. While out_ready is low the current result holds and the
//   counters do not advance.
module signed_permutation_orbit
    import spo_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [IDX_W-1:0]         first_in,
    input  logic [IDX_W-1:0]         second_in,
    input  logic [IDX_W-1:0]         third_in,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [ENT_W-1:0]  out_first,
    output logic signed [ENT_W-1:0]  out_second,
    output logic signed [ENT_W-1:0]  out_third,
    output logic [SIZE_W-1:0]        orbit_size,
    output logic                     last_one,
    output logic                     order_error
);

    spo_cmd_t    cmd;
    spo_status_t status;

    spo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    spo_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .first_in    (first_in),
        .second_in   (second_in),
        .third_in    (third_in),
        .status      (status),
        .out_first   (out_first),
        .out_second  (out_second),
        .out_third   (out_third),
        .orbit_size  (orbit_size),
        .last_one    (last_one),
        .order_error (order_error)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("request taken while results pending");

    a_first_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
        else $error("no result after request");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_one) |=> out_valid)
        else $error("run ended before last result");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && order_error) |-> (last_one && orbit_size == SIZE_W'(1)))
        else $error("error result not a single result");

endmodule
